[rtl/niox_pkg.sv]
package niox_pkg;

   localparam int MAX_AXES = 3;
   localparam int DIV_BITS = 48;

   // register indexes on the csr port
   localparam logic [2:0] REG_NUM_AXES = 3'd0;
   localparam logic [2:0] REG_LENGTH_0 = 3'd1;
   localparam logic [2:0] REG_LENGTH_1 = 3'd2;
   localparam logic [2:0] REG_LENGTH_2 = 3'd3;
   localparam logic [2:0] REG_ORIGIN_0 = 3'd4;
   localparam logic [2:0] REG_ORIGIN_1 = 3'd5;
   localparam logic [2:0] REG_ORIGIN_2 = 3'd6;

   localparam logic signed [63:0] BIG = 64'sd1 <<< 50;
   localparam logic signed [63:0] OFF_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] OFF_MIN = -OFF_MAX - 64'sd1;
   localparam logic signed [63:0] C32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] C32_MIN = -C32_MAX - 64'sd1;

   typedef struct packed {
      logic [1:0]         n;
      logic [15:0]        len0;
      logic [15:0]        len1;
      logic signed [15:0] org0;
      logic signed [15:0] org1;
      logic signed [15:0] org2;
   } cfg_type;

   typedef struct packed {
      logic               mode;
      logic               neg;
      logic [1:0]         n;
      logic signed [47:0] offs;
      logic               ovf;
      logic [47:0]        quo_a;
   } tag_type;

   typedef struct packed {
      logic               ovf;
      logic signed [31:0] value;
   } coord_sat_type;

   function automatic logic [1:0] axes_used(input logic [1:0] raw);
      logic [1:0] n;
      n = (raw == 2'd0) ? 2'd1 : raw;
      if (32'(n) > MAX_AXES) n = 2'(MAX_AXES);
      return n;
   endfunction

   // one Horner step, product and sum clamped to +-2^50
   function automatic logic signed [51:0] horner(input logic signed [51:0] acc,
                                                 input logic [15:0] len,
                                                 input logic signed [32:0] term);
      logic signed [68:0] prod;
      logic signed [52:0] sum;
      logic signed [51:0] pc;
      prod = 69'(acc) * $signed({53'd0, len});
      if (prod > 69'(BIG)) pc = 52'(BIG);
      else if (prod < -69'(BIG)) pc = -52'(BIG);
      else pc = 52'(prod);
      sum = 53'(pc) + 53'(term);
      if (sum > 53'(BIG)) sum = 53'(BIG);
      if (sum < -53'(BIG)) sum = -53'(BIG);
      return 52'(sum);
   endfunction

   function automatic coord_sat_type coord_sat(input logic neg, input logic [47:0] mag,
                                               input logic signed [15:0] org);
      logic signed [49:0] v;
      coord_sat_type r;
      v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      v = v - 50'(org);
      r.ovf = 1'b1;
      if (v > 50'(C32_MAX)) r.value = 32'(C32_MAX);
      else if (v < 50'(C32_MIN)) r.value = 32'(C32_MIN);
      else begin
         r.value = 32'(v);
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/nd_index_offset_converter.sv]
// channel | direction | ports                              | accepted when
// req     | in        | req_valid, req_stall, req_* fields | req_valid & !req_stall
// rsp     | out       | rsp_valid, rsp_stall, rsp_* fields | rsp_valid & !rsp_stall
// csr     | in        | csr_we, csr_index, csr_wdata       | csr_we
//
// One item per cycle sustained while no result is stalled; the pipeline is 4 fold
// stages, 2 x 48 bit-per-cell division cells and 1 output register.
// The whole pipeline moves as one; a stalled result freezes it and req_stall
// follows rsp_stall while a result is held.
// Reset (synchronous) empties the pipeline and restores the register defaults.
module nd_index_offset_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic signed [31:0] req_coord_in_0,
   input  logic signed [31:0] req_coord_in_1,
   input  logic signed [31:0] req_coord_in_2,
   input  logic signed [47:0] req_offset_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_offset_out,
   output logic signed [31:0] rsp_coord_out_0,
   output logic signed [31:0] rsp_coord_out_1,
   output logic signed [31:0] rsp_coord_out_2,
   output logic               rsp_overflow,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   localparam int NB = niox_pkg::DIV_BITS;

   niox_pkg::cfg_type cfg_ff;
   logic [15:0]       len2_ff;   // held, does not affect the conversion
   logic [31:0]       stride_ff; // len0 * len1, registered from the length registers
   logic              adv;
   logic [1:0]        n;
   logic [31:0]       div_a, div_b;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.n    <= 2'd1;
         cfg_ff.len0 <= 16'd1;
         cfg_ff.len1 <= 16'd1;
         len2_ff     <= 16'd1;
         cfg_ff.org0 <= '0;
         cfg_ff.org1 <= '0;
         cfg_ff.org2 <= '0;
      end else if (csr_we) begin
         case (csr_index)
            niox_pkg::REG_NUM_AXES: cfg_ff.n    <= csr_wdata[1:0];
            niox_pkg::REG_LENGTH_0: cfg_ff.len0 <= csr_wdata;
            niox_pkg::REG_LENGTH_1: cfg_ff.len1 <= csr_wdata;
            niox_pkg::REG_LENGTH_2: len2_ff     <= csr_wdata;
            niox_pkg::REG_ORIGIN_0: cfg_ff.org0 <= csr_wdata;
            niox_pkg::REG_ORIGIN_1: cfg_ff.org1 <= csr_wdata;
            niox_pkg::REG_ORIGIN_2: cfg_ff.org2 <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      stride_ff <= 32'(cfg_ff.len0) * 32'(cfg_ff.len1);
   end

   // first chain splits off the top axis, second splits axis 1 from axis 0 when three axes are used;
   // a zero divisor passes the dividend on as remainder
   always_comb begin
      n = niox_pkg::axes_used(cfg_ff.n);
      priority if (n == 2'd3) div_a = stride_ff;
      else if (n == 2'd2) div_a = 32'(cfg_ff.len0);
      else div_a = (len2_ff == 16'd0) ? 32'd0 : 32'd0;
      div_b = (n == 2'd3) ? 32'(cfg_ff.len0) : 32'd0;
   end

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic              f_valid;
   logic [47:0]       f_mag;
   niox_pkg::tag_type f_tag;

   niox_fold u_fold (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .load    (req_valid),
      .cfg     (cfg_ff),
      .mode    (req_mode),
      .coord_0 (req_coord_in_0),
      .coord_1 (req_coord_in_1),
      .coord_2 (req_coord_in_2),
      .offset  (req_offset_in),
      .valid_o (f_valid),
      .mag_o   (f_mag),
      .tag_o   (f_tag)
   );

   // cell chain: index 0 feeds chain A, NB feeds chain B, 2*NB is the end
   logic              cv [0:2*NB];
   logic [47:0]       cr [0:2*NB];
   logic [47:0]       cq [0:2*NB];
   niox_pkg::tag_type ct [0:2*NB];

   assign cv[0] = f_valid;
   assign cr[0] = '0;
   assign cq[0] = f_mag;
   assign ct[0] = f_tag;

   for (genvar g = 0; g < 2 * NB; g++) begin : g_cell
      logic              vi;
      logic [47:0]       ri, qi;
      niox_pkg::tag_type ti;
      always_comb begin
         vi = cv[g];
         ri = cr[g];
         qi = cq[g];
         ti = ct[g];
         if (g == NB) begin
            // hand over: quotient of A is kept, its remainder is divided again
            ri       = '0;
            qi       = cr[g];
            ti.quo_a = cq[g];
         end
      end
      niox_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .divisor ((g < NB) ? div_a : div_b),
         .valid_i (vi),
         .rem_i   (ri),
         .quo_i   (qi),
         .tag_i   (ti),
         .valid_o (cv[g+1]),
         .rem_o   (cr[g+1]),
         .quo_o   (cq[g+1]),
         .tag_o   (ct[g+1])
      );
   end

   niox_post u_post (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .cfg         (cfg_ff),
      .valid_i     (cv[2*NB]),
      .quo_b       (cq[2*NB]),
      .rem_b       (cr[2*NB]),
      .tag_i       (ct[2*NB]),
      .valid_o     (rsp_valid),
      .offset_out  (rsp_offset_out),
      .coord_out_0 (rsp_coord_out_0),
      .coord_out_1 (rsp_coord_out_1),
      .coord_out_2 (rsp_coord_out_2),
      .overflow    (rsp_overflow)
   );
endmodule

[rtl/niox_fold.sv]
module niox_fold (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               load,
   input  niox_pkg::cfg_type  cfg,
   input  logic               mode,
   input  logic signed [31:0] coord_0,
   input  logic signed [31:0] coord_1,
   input  logic signed [31:0] coord_2,
   input  logic signed [47:0] offset,
   output logic               valid_o,
   output logic [47:0]        mag_o,
   output niox_pkg::tag_type  tag_o
);
   // P0: captured item
   logic               v0_ff, mode0_ff;
   logic signed [31:0] c0_ff, c1_ff, c2_ff;
   logic signed [47:0] off_ff;
   // P1: origin sums, magnitude
   logic               v1_ff, mode1_ff, neg1_ff;
   logic signed [51:0] acc1_ff;
   logic signed [32:0] t0_1_ff, t1_1_ff;
   logic [47:0]        mag1_ff;
   // P2: upper Horner step
   logic               v2_ff, mode2_ff, neg2_ff;
   logic signed [51:0] acc2_ff;
   logic signed [32:0] t0_2_ff;
   logic [47:0]        mag2_ff;
   // P3: lower Horner step and 48 bit clamp
   logic               v3_ff;
   logic [47:0]        mag3_ff;
   niox_pkg::tag_type  tag3_ff;

   logic [1:0]         n;
   logic signed [32:0] s0, s1, s2;
   logic signed [51:0] acc1_in, acc2_in, acc3;
   niox_pkg::tag_type  tag3_in;

   always_comb begin
      n  = niox_pkg::axes_used(cfg.n);
      s0 = 33'(c0_ff) + 33'(cfg.org0);
      s1 = 33'(c1_ff) + 33'(cfg.org1);
      s2 = 33'(c2_ff) + 33'(cfg.org2);
      priority if (n == 2'd3) acc1_in = 52'(s2);
      else if (n == 2'd2) acc1_in = 52'(s1);
      else acc1_in = 52'(s0);
      acc2_in = (n == 2'd3) ? niox_pkg::horner(acc1_ff, cfg.len1, t1_1_ff) : acc1_ff;
      acc3    = (n != 2'd1) ? niox_pkg::horner(acc2_ff, cfg.len0, t0_2_ff) : acc2_ff;
      tag3_in.mode  = mode2_ff;
      tag3_in.neg   = neg2_ff;
      tag3_in.n     = n;
      tag3_in.quo_a = '0;
      tag3_in.ovf   = 1'b0;
      if (mode2_ff) tag3_in.offs = '0;
      else if (acc3 > 52'(niox_pkg::OFF_MAX)) begin
         tag3_in.offs = 48'(niox_pkg::OFF_MAX);
         tag3_in.ovf  = 1'b1;
      end else if (acc3 < 52'(niox_pkg::OFF_MIN)) begin
         tag3_in.offs = 48'(niox_pkg::OFF_MIN);
         tag3_in.ovf  = 1'b1;
      end else tag3_in.offs = 48'(acc3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= load;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode0_ff <= mode;
         c0_ff    <= coord_0;
         c1_ff    <= coord_1;
         c2_ff    <= coord_2;
         off_ff   <= offset;
         mode1_ff <= mode0_ff;
         neg1_ff  <= off_ff[47];
         mag1_ff  <= off_ff[47] ? 48'(-off_ff) : 48'(off_ff);
         acc1_ff  <= acc1_in;
         t0_1_ff  <= s0;
         t1_1_ff  <= s1;
         mode2_ff <= mode1_ff;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         acc2_ff  <= acc2_in;
         t0_2_ff  <= t0_1_ff;
         mag3_ff  <= mag2_ff;
         tag3_ff  <= tag3_in;
      end
   end

   assign valid_o = v3_ff;
   assign mag_o   = mag3_ff;
   assign tag_o   = tag3_ff;
endmodule

[rtl/niox_div_cell.sv]
module niox_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [31:0]       divisor,
   input  logic              valid_i,
   input  logic [47:0]       rem_i,
   input  logic [47:0]       quo_i,
   input  niox_pkg::tag_type tag_i,
   output logic              valid_o,
   output logic [47:0]       rem_o,
   output logic [47:0]       quo_o,
   output niox_pkg::tag_type tag_o
);
   logic [48:0] trial;
   logic        take;
   logic        valid_ff;
   logic [47:0] rem_ff, quo_ff, rem_in;
   niox_pkg::tag_type tag_ff;

   // one restoring step; a zero divisor never subtracts, so the
   // dividend collects whole in the remainder
   always_comb begin
      trial  = {rem_i, quo_i[47]};
      take   = (divisor != 32'd0) && (trial >= 49'(divisor));
      rem_in = take ? 48'(trial - 49'(divisor)) : trial[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= valid_i;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_i[46:0], take};
         tag_ff <= tag_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign quo_o   = quo_ff;
   assign tag_o   = tag_ff;
endmodule

[rtl/niox_post.sv]
module niox_post (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  niox_pkg::cfg_type  cfg,
   input  logic               valid_i,
   input  logic [47:0]        quo_b,
   input  logic [47:0]        rem_b,
   input  niox_pkg::tag_type  tag_i,
   output logic               valid_o,
   output logic signed [47:0] offset_out,
   output logic signed [31:0] coord_out_0,
   output logic signed [31:0] coord_out_1,
   output logic signed [31:0] coord_out_2,
   output logic               overflow
);
   niox_pkg::coord_sat_type a_top, a_mid_q, a_mid_b, a_low;
   logic signed [31:0] c0_in, c1_in, c2_in;
   logic               ovf_in;
   logic               valid_ff;
   logic signed [47:0] off_ff;
   logic signed [31:0] c0_ff, c1_ff, c2_ff;
   logic               ovf_ff;

   always_comb begin
      a_top   = niox_pkg::coord_sat(tag_i.neg, tag_i.quo_a, cfg.org2);
      a_mid_q = niox_pkg::coord_sat(tag_i.neg, quo_b, cfg.org1);
      a_mid_b = niox_pkg::coord_sat(tag_i.neg, tag_i.quo_a, cfg.org1);
      a_low   = niox_pkg::coord_sat(tag_i.neg, rem_b, cfg.org0);
      c0_in = '0;
      c1_in = '0;
      c2_in = '0;
      ovf_in = tag_i.ovf;
      if (tag_i.mode) begin
         c0_in  = a_low.value;
         ovf_in = a_low.ovf;
         unique case (tag_i.n)
            2'd3: begin
               c2_in  = a_top.value;
               c1_in  = a_mid_q.value;
               ovf_in = a_low.ovf | a_top.ovf | a_mid_q.ovf;
            end
            2'd2: begin
               c1_in  = a_mid_b.value;
               ovf_in = a_low.ovf | a_mid_b.ovf;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= valid_i;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff <= tag_i.offs;
         c0_ff  <= c0_in;
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         ovf_ff <= ovf_in;
      end
   end

   assign valid_o     = valid_ff;
   assign offset_out  = off_ff;
   assign coord_out_0 = c0_ff;
   assign coord_out_1 = c1_ff;
   assign coord_out_2 = c2_ff;
   assign overflow    = ovf_ff;
endmodule

[rtl/niox_checker.sv]
module niox_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [47:0] rsp_offset_out,
   input logic signed [31:0] rsp_coord_out_0,
   input logic signed [31:0] rsp_coord_out_1,
   input logic signed [31:0] rsp_coord_out_2,
   input logic               rsp_overflow
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_offset_out) && $stable(rsp_coord_out_0))
      else $error("stalled rsp item changed");

   a_one_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_offset_out == 48'sd0 ||
         (rsp_coord_out_0 == 32'sd0 && rsp_coord_out_1 == 32'sd0 &&
          rsp_coord_out_2 == 32'sd0))
      else $error("rsp item carries both offset and coordinates");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a held rsp item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");
endmodule

bind nd_index_offset_converter niox_checker u_niox_checker (.*);
